// ===== src/asum_pkg.sv =====
// Shared types and constants for the advertising service UUID matcher.
package asum_pkg;

  localparam int unsigned SlotBytes = 16;
  localparam int unsigned SlotIdxW  = $clog2(SlotBytes);
  localparam int unsigned UuidW     = 8 * SlotBytes;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] CFG_UUID_LOW  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_UUID_HIGH = 1'b1;

  localparam logic [7:0] AD_TYPE_UUID128_PART = 8'h06;
  localparam logic [7:0] AD_TYPE_UUID128_FULL = 8'h07;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic uuid_found;
    logic field_overrun;
  } asum_result_t;

endpackage

// ===== src/asum_ifs.sv =====
// Valid/ready channel interfaces for payload bytes and packet results.
interface asum_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface asum_out_if;
  logic valid;
  logic ready;
  logic uuid_found;
  logic field_overrun;

  modport source (output valid, output uuid_found, output field_overrun, input ready);
  modport sink   (input valid, input uuid_found, input field_overrun, output ready);
endinterface

// ===== src/asum_parser.sv =====
// AD structure walker with 16-byte UUID slot comparison.
module asum_parser
  import asum_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  byte_t            data_byte,
  input  logic             last,
  input  logic [UuidW-1:0] uuid,
  output asum_result_t     result
);

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [SlotIdxW-1:0] SlotLast = SlotIdxW'(SlotBytes - 1);

  logic [1:0]          phase_r,      phase_nxt;
  byte_t               left_r,       left_nxt;
  logic                uuid_fld_r,   uuid_fld_nxt;
  logic [SlotIdxW-1:0] slot_idx_r,   slot_idx_nxt;
  logic                slot_eq_r,    slot_eq_nxt;
  logic                found_r,      found_nxt;

  byte_t wanted;
  logic  slot_eq_now;
  byte_t left_dec;

  assign wanted      = uuid[{slot_idx_r, 3'b000} +: 8];
  assign slot_eq_now = slot_eq_r && (data_byte == wanted);
  assign left_dec    = left_r - 8'd1;

  always_comb begin
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    uuid_fld_nxt = uuid_fld_r;
    slot_idx_nxt = slot_idx_r;
    slot_eq_nxt  = slot_eq_r;
    found_nxt    = found_r;
    unique case (phase_r)
      PH_LEN: begin
        // a zero length byte stands alone
        if (data_byte != 8'd0) begin
          left_nxt  = data_byte;
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        left_nxt     = left_dec;
        uuid_fld_nxt = (data_byte == AD_TYPE_UUID128_PART) ||
                       (data_byte == AD_TYPE_UUID128_FULL);
        slot_idx_nxt = '0;
        slot_eq_nxt  = 1'b1;
        phase_nxt    = (left_dec == 8'd0) ? PH_LEN : PH_DATA;
      end
      default: begin
        if (uuid_fld_r) begin
          if (slot_idx_r == SlotLast) begin
            if (slot_eq_now) found_nxt = 1'b1;
            slot_idx_nxt = '0;
            slot_eq_nxt  = 1'b1;
          end else begin
            slot_idx_nxt = slot_idx_r + 1'b1;
            slot_eq_nxt  = slot_eq_now;
          end
        end
        left_nxt = left_dec;
        if (left_dec == 8'd0) phase_nxt = PH_LEN;
      end
    endcase
  end

  assign result.uuid_found    = found_nxt;
  assign result.field_overrun = (phase_nxt != PH_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEN;
      left_r     <= '0;
      uuid_fld_r <= 1'b0;
      slot_idx_r <= '0;
      slot_eq_r  <= 1'b1;
      found_r    <= 1'b0;
    end else if (take) begin
      if (last) begin
        // packet done: back to the start state
        phase_r    <= PH_LEN;
        left_r     <= '0;
        uuid_fld_r <= 1'b0;
        slot_idx_r <= '0;
        slot_eq_r  <= 1'b1;
        found_r    <= 1'b0;
      end else begin
        phase_r    <= phase_nxt;
        left_r     <= left_nxt;
        uuid_fld_r <= uuid_fld_nxt;
        slot_idx_r <= slot_idx_nxt;
        slot_eq_r  <= slot_eq_nxt;
        found_r    <= found_nxt;
      end
    end
  end

endmodule

// ===== src/adv_service_uuid_matcher_core.sv =====
// Top level of the advertising payload 128-bit service UUID matcher.
//
//  channel | dir | handshake          | carries
//  --------+-----+--------------------+----------------------------------
//  in_ch   | in  | valid/ready        | payload_byte, last_byte
//  out_ch  | out | valid/ready        | uuid_found, field_overrun
//  cfg_*   | in  | cfg_we, no wait    | cfg_index selects uuid_low/high
//
// One payload byte per cycle: parser state advances at the edge that takes
// the item, and the packet result lands in the output register at the same
// edge when the item carries last_byte. The output register parts the two
// sides: a new byte is taken while the result register is empty or drained
// in that cycle. Synchronous active-low reset clears parser state, the UUID
// registers and the output valid.
module adv_service_uuid_matcher_core
  import asum_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  asum_in_if.sink             in_ch,
  asum_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic [CfgDataW-1:0] uuid_low_r;
  logic [CfgDataW-1:0] uuid_high_r;
  logic                out_valid_r;
  asum_result_t        out_res_r;
  asum_result_t        res_now;
  logic                take;

  // Accept a byte whenever the result slot is free or emptying now.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  // Configuration writes: whole 64-bit halves of the UUID.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uuid_low_r  <= '0;
      uuid_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UUID_LOW:  uuid_low_r  <= cfg_wdata;
        CFG_UUID_HIGH: uuid_high_r <= cfg_wdata;
        default:       uuid_low_r  <= uuid_low_r;
      endcase
    end
  end

  asum_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_ch.payload_byte),
    .last      (in_ch.last_byte),
    .uuid      ({uuid_high_r, uuid_low_r}),
    .result    (res_now)
  );

  // Output register: load on the last byte of a packet, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && in_ch.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_ch.last_byte) begin
      out_res_r <= res_now;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.uuid_found    = out_res_r.uuid_found;
  assign out_ch.field_overrun = out_res_r.field_overrun;

endmodule

// ===== tb/tb_adv_service_uuid_matcher_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the advertising payload 128-bit service UUID matcher.
module tb_adv_service_uuid_matcher_core
  import asum_pkg::*;
();

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned BulkBytes   = 1750;
  localparam int unsigned BulkPhases  = 6;
  localparam int unsigned IdlePct     = 26;

  // Where the parser stands inside the current AD structure.
  typedef enum logic [1:0] {
    EXPECT_LEN,
    EXPECT_TYPE,
    IN_DATA
  } parse_e;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  asum_in_if  in_ch ();
  asum_out_if out_ch ();

  adv_service_uuid_matcher_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the matcher: wanted UUID and parser state.
  logic [UuidW-1:0]    want_uuid;
  parse_e              phase;
  byte_t               bytes_to_go;
  logic                in_uuid_list;
  logic [SlotIdxW-1:0] slot_pos;
  logic                slot_still_equal;
  logic                packet_matched;

  // Packet verdicts still owed by the block, oldest first.
  asum_result_t        pending_verdicts[$];
  asum_result_t        oldest;

  // Bytes of the packet being assembled for sending.
  byte_t               packet_q[$];

  int unsigned         bytes_sent  = 0;
  int unsigned         mismatches  = 0;
  int unsigned         cycle_count = 0;
  // Set to run a stretch with neither side idling.
  bit                  steady      = 1'b0;

  // Return the parser to its state at the start of a packet.
  function automatic void restart_packet();
    phase            = EXPECT_LEN;
    bytes_to_go      = '0;
    in_uuid_list     = 1'b0;
    slot_pos         = '0;
    slot_still_equal = 1'b1;
    packet_matched   = 1'b0;
  endfunction

  // Advance the shadow parser by one accepted byte; queue a verdict at
  // packet end.
  function automatic void track_byte(byte_t b, logic last);
    asum_result_t verdict;
    case (phase)
      EXPECT_LEN: begin
        // A zero length byte is a structure of its own: stay here.
        if (b != 8'h00) begin
          bytes_to_go = b;
          phase       = EXPECT_TYPE;
        end
      end
      EXPECT_TYPE: begin
        bytes_to_go--;
        in_uuid_list     = (b == AD_TYPE_UUID128_PART) || (b == AD_TYPE_UUID128_FULL);
        slot_pos         = '0;
        slot_still_equal = 1'b1;
        phase            = (bytes_to_go == 8'h00) ? EXPECT_LEN : IN_DATA;
      end
      default: begin
        if (in_uuid_list) begin
          if (b != want_uuid[8*slot_pos +: 8]) slot_still_equal = 1'b0;
          // Only a full slot can count; a trailing partial slot never closes.
          if (slot_pos == SlotIdxW'(SlotBytes - 1)) begin
            if (slot_still_equal) packet_matched = 1'b1;
            slot_still_equal = 1'b1;
          end
          slot_pos = slot_pos + 1'b1;
        end
        bytes_to_go--;
        if (bytes_to_go == 8'h00) phase = EXPECT_LEN;
      end
    endcase
    if (last) begin
      verdict.uuid_found    = packet_matched;
      verdict.field_overrun = (phase != EXPECT_LEN);
      pending_verdicts.push_back(verdict);
      restart_packet();
    end
  endfunction

  // Append UUID bytes first..first+count-1 as the block compares them.
  function automatic void push_wanted(int unsigned first, int unsigned count);
    for (int unsigned k = first; k < first + count; k++) begin
      packet_q.push_back(want_uuid[8*k +: 8]);
    end
  endfunction

  // Append a 128-bit UUID list structure: whole slots, then a partial tail.
  function automatic void push_uuid_list(int unsigned slots, int unsigned tail);
    int unsigned pick;
    packet_q.push_back(byte_t'(1 + SlotBytes * slots + tail));
    packet_q.push_back($urandom_range(1) ? AD_TYPE_UUID128_FULL : AD_TYPE_UUID128_PART);
    repeat (slots) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        push_wanted(0, SlotBytes);
      end else if (pick < 7) begin
        // Near miss: one bit flipped somewhere in the slot.
        push_wanted(0, SlotBytes);
        packet_q[packet_q.size() - 1 - $urandom_range(SlotBytes - 1)] ^=
          byte_t'(8'h01 << $urandom_range(7));
      end else begin
        repeat (SlotBytes) packet_q.push_back(byte_t'($urandom));
      end
    end
    // The tail is mostly a true UUID prefix, which must still not match.
    if ($urandom_range(9) < 7) begin
      push_wanted(0, tail);
    end else begin
      repeat (tail) packet_q.push_back(byte_t'($urandom));
    end
  endfunction

  // Build one random packet: mostly well-formed structures, some noise,
  // and some cut short to end inside a structure.
  function automatic void make_random_packet();
    int unsigned fields;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 30)) packet_q.push_back(byte_t'($urandom));
      return;
    end
    fields = $urandom_range(1, 4);
    repeat (fields) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        // Longest legal structure: length byte 255.
        push_uuid_list(15, 14);
      end else if (pick < 47) begin
        push_uuid_list($urandom_range(3),
                       ($urandom_range(2) == 0) ? $urandom_range(SlotBytes - 1) : 0);
      end else if (pick < 82) begin
        len = $urandom_range(1, 13);
        packet_q.push_back(byte_t'(len));
        repeat (len) packet_q.push_back(byte_t'($urandom));
      end else begin
        packet_q.push_back(8'h00);
      end
    end
    if ($urandom_range(99) < 20 && packet_q.size() > 1) begin
      cut = $urandom_range(1, packet_q.size() - 1);
      while (packet_q.size() > cut) void'(packet_q.pop_back());
    end
  endfunction

  // Drive one item: idle a random number of cycles, then hold it until taken.
  task automatic send_byte(input byte_t value, input logic last);
    int unsigned gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < IdlePct) gap++;
    end
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= value;
    in_ch.last_byte    <= last;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    track_byte(value, last);
  endtask

  // Send the assembled bytes; mark the final one as packet end if asked.
  task automatic send_packet(input logic ends_packet);
    for (int i = 0; i < packet_q.size(); i++) begin
      send_byte(packet_q[i], ends_packet && (i == packet_q.size() - 1));
    end
    bytes_sent += packet_q.size();
    packet_q.delete();
  endtask

  // Drop valid and wait until every owed verdict has come out.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Single register write; the block takes it at the next rising edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_UUID_LOW) begin
      want_uuid[CfgDataW-1:0] = value;
    end else begin
      want_uuid[UuidW-1:CfgDataW] = value;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_uuid(input logic [CfgDataW-1:0] low, input logic [CfgDataW-1:0] high);
    drain();
    write_reg(CFG_UUID_LOW, low);
    write_reg(CFG_UUID_HIGH, high);
  endtask

  // Tiny packets: lone zero length, lone nonzero length, type byte last,
  // a type-only structure, and zero lengths between structures.
  task automatic test_short_packets();
    load_uuid(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    packet_q = '{8'h00};
    send_packet(1'b1);
    packet_q = '{8'hFF};
    send_packet(1'b1);
    packet_q = '{8'h02, AD_TYPE_UUID128_FULL};
    send_packet(1'b1);
    packet_q = '{8'h01, AD_TYPE_UUID128_PART};
    send_packet(1'b1);
    packet_q = '{8'h00, 8'h00, 8'h02, 8'h80, 8'hFF, 8'h00};
    send_packet(1'b1);
  endtask

  // A full matching slot completed by the packet's last byte.
  task automatic test_match_on_last();
    packet_q = '{8'h11, AD_TYPE_UUID128_FULL};
    push_wanted(0, SlotBytes);
    send_packet(1'b1);
  endtask

  // A 15-byte UUID prefix as a partial slot, and a full UUID in a field
  // of another type: neither may match.
  task automatic test_unmatched_fields();
    packet_q = '{8'h10, AD_TYPE_UUID128_PART};
    push_wanted(0, SlotBytes - 1);
    push_wanted(0, 0);
    packet_q.push_back(8'h11);
    packet_q.push_back(8'h03);
    push_wanted(0, SlotBytes);
    send_packet(1'b1);
  endtask

  // Change the upper UUID half between bytes 7 and 8 of a slot; the new
  // value applies to the bytes compared after the write.
  task automatic test_write_mid_packet();
    packet_q = '{8'h11, AD_TYPE_UUID128_FULL};
    push_wanted(0, SlotBytes / 2);
    send_packet(1'b0);
    drain();
    write_reg(CFG_UUID_HIGH, {$urandom, $urandom});
    push_wanted(SlotBytes / 2, SlotBytes / 2);
    send_packet(1'b1);
  endtask

  // Bulk random packets under several UUID settings, extremes first.
  // One phase runs with no idling on either side.
  task automatic test_random_packets();
    int unsigned target;
    for (int s = 0; s < BulkPhases; s++) begin
      case (s)
        0: load_uuid('0, '0);
        1: load_uuid('1, '1);
        2: load_uuid('1, '0);
        default: load_uuid({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      steady = (s == 3);
      target = bytes_sent + BulkBytes / BulkPhases;
      while (bytes_sent < target) begin
        make_random_packet();
        send_packet(1'b1);
      end
    end
    steady = 1'b0;
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= ReportMax) $display("%0t: %s", $time, msg);
  endtask

  // Result side stalls at random, except during the steady stretch.
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  // Compare each taken verdict with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        report($sformatf("verdict with none pending: uuid_found=%0b field_overrun=%0b",
                         out_ch.uuid_found, out_ch.field_overrun));
      end else begin
        oldest = pending_verdicts.pop_front();
        if (out_ch.uuid_found !== oldest.uuid_found) begin
          report($sformatf("uuid_found expected %0b got %0b",
                           oldest.uuid_found, out_ch.uuid_found));
        end
        if (out_ch.field_overrun !== oldest.field_overrun) begin
          report($sformatf("field_overrun expected %0b got %0b",
                           oldest.field_overrun, out_ch.field_overrun));
        end
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_adv_service_uuid_matcher_core: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_UUID_LOW;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.payload_byte = '0;
    in_ch.last_byte    = 1'b0;
    out_ch.ready       = 1'b0;
    want_uuid          = '0;
    restart_packet();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_packets();
    test_match_on_last();
    test_unmatched_fields();
    test_write_mid_packet();
    test_random_packets();

    drain();
    if (mismatches == 0) begin
      $display("tb_adv_service_uuid_matcher_core: PASS");
    end else begin
      $display("tb_adv_service_uuid_matcher_core: FAIL");
    end
    $finish;
  end

endmodule
